FILE: rtl/core/ssrer_pkg.sv
// ----------------------------------------------------------------------------
// ssrer_pkg
// Shared types and constants for the sensor scan rising-edge reporter.
// ----------------------------------------------------------------------------
package ssrer_pkg;

  // Default number of bytes in one sensor scan
  localparam int unsigned ScanBytesDef = 10;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModuleW  = 3;
  localparam int unsigned ContactW = 5;
  localparam int unsigned BitIdxW  = 3;

  // Contacts per half-module; odd bytes carry the upper half
  localparam logic [ContactW-1:0] HalfContacts = ContactW'(8);

  // Rising-edge information for one accepted byte
  typedef struct packed {
    logic               hit;      // events to report for this byte
    logic [ByteW-1:0]   mask;     // bits that went from 0 to 1
    logic [ModuleW-1:0] mod_idx;  // byte position / 2, truncated
    logic               odd;      // odd byte position
  } edge_t;

endpackage

FILE: rtl/core/ssrer_scan_mem.sv
// ----------------------------------------------------------------------------
// ssrer_scan_mem
// Byte position counter, baseline flag and the per-position history store.
// The entry for the next position is read ahead so that its value is ready
// in a register when the next beat arrives.
// ----------------------------------------------------------------------------
module ssrer_scan_mem #(
  parameter int unsigned SCAN_BYTES = ssrer_pkg::ScanBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ssrer_pkg::ByteW-1:0]   sensor_byte_i,
  output ssrer_pkg::edge_t              edge_o
);
  import ssrer_pkg::*;

  localparam int unsigned PosW = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(SCAN_BYTES - 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             base_q, base_d;
  logic [ByteW-1:0] mem_q [SCAN_BYTES];
  logic [ByteW-1:0] rd_q;
  logic [PosW+2:0]  pos_w;
  logic [ByteW-1:0] rising;

  // Position wraps at the end of a scan; first wrap ends the baseline scan
  always_comb begin
    pos_d  = pos_q;
    base_d = base_q;
    if (accept_i) begin
      if (pos_q == LastPos) begin
        pos_d  = '0;
        base_d = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      base_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      base_q <= base_d;
    end
  end

  // History store: write current position, read ahead the next one.
  // Entries not yet written are only read during the baseline scan.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem_q[pos_q] <= sensor_byte_i;
      rd_q         <= mem_q[pos_d];
    end
  end

  // Rising bits and event addressing
  always_comb begin
    pos_w          = (PosW+3)'(pos_q);
    rising         = sensor_byte_i & ~rd_q;
    edge_o.hit     = base_q && (rising != '0);
    edge_o.mask    = rising;
    edge_o.mod_idx = pos_w[3:1];
    edge_o.odd     = pos_q[0];
  end

  // Position never leaves the scan
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position out of range");

  // No events during the baseline scan
  a_no_base_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !base_q |-> !edge_o.hit)
    else $error("event raised before baseline complete");

  // Baseline completes only on a wrap to position zero
  a_base_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(base_q) |-> (pos_q == '0))
    else $error("baseline set away from scan start");

endmodule

FILE: rtl/core/ssrer_event_ser.sv
// ----------------------------------------------------------------------------
// ssrer_event_ser
// Holds the rising mask of one byte and emits one event per cycle into the
// result register unless stalled, bit 7 first; flags the byte's last event.
// ----------------------------------------------------------------------------
module ssrer_event_ser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  ssrer_pkg::edge_t               edge_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssrer_pkg::ModuleW-1:0]  module_letter_o,
  output logic [ssrer_pkg::ContactW-1:0] contact_number_o,
  output logic                           last_event_o
);
  import ssrer_pkg::*;

  logic                a_valid_q, a_valid_d;
  logic [ByteW-1:0]    a_mask_q, a_mask_d;
  logic [ModuleW-1:0]  a_mod_q;
  logic                a_odd_q;
  logic [BitIdxW-1:0]  sel;
  logic [ByteW-1:0]    mask_rest;
  logic                out_load;
  logic                a_done;
  logic                out_valid_q;
  logic [ModuleW-1:0]  mod_q;
  logic [ContactW-1:0] contact_q, contact_d;
  logic                last_q;

  // Highest pending bit is reported first
  always_comb begin
    sel = '0;
    for (int b = 0; b < ByteW; b++) begin
      if (a_mask_q[b]) begin
        sel = BitIdxW'(b);
      end
    end
    mask_rest = a_mask_q & ~(ByteW'(1) << sel);
    contact_d = ContactW'(ByteW) - ContactW'(sel)
              + (a_odd_q ? HalfContacts : '0);
  end

  // Result slot free or draining this cycle
  assign out_load = a_valid_q && (!out_valid_q || !out_stall_i);
  assign a_done   = out_load && (mask_rest == '0);
  assign busy_o   = a_valid_q && !a_done;

  // Pending mask stage
  always_comb begin
    a_valid_d = a_valid_q;
    a_mask_d  = a_mask_q;
    if (out_load) begin
      a_mask_d = mask_rest;
    end
    if (a_done) begin
      a_valid_d = 1'b0;
    end
    if (accept_i && edge_i.hit) begin
      a_valid_d = 1'b1;
      a_mask_d  = edge_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mask_q <= a_mask_d;
    if (accept_i && edge_i.hit) begin
      a_mod_q <= edge_i.mod_idx;
      a_odd_q <= edge_i.odd;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mod_q     <= a_mod_q;
      contact_q <= contact_d;
      last_q    <= (mask_rest == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign module_letter_o  = mod_q;
  assign contact_number_o = contact_q;
  assign last_event_o     = last_q;

  // A held byte always has events left
  a_mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_mask_q != '0))
    else $error("pending stage valid with empty mask");

  // A non-final event implies more events are still held
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> a_valid_q)
    else $error("non-final event without pending events");

  // Contact numbers stay within one module
  a_contact_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (contact_q >= ContactW'(1) && contact_q <= ContactW'(16)))
    else $error("contact number out of range");

endmodule

FILE: rtl/core/sensor_scan_rising_edge_reporter.sv
// ----------------------------------------------------------------------------
// sensor_scan_rising_edge_reporter
// Reports sensor contacts that rise from 0 to 1 in a repeating sensor dump.
// ----------------------------------------------------------------------------
// Bytes of the dump arrive one beat at a time, SCAN_BYTES to a scan. Each
// beat is compared with the byte seen at the same position in the previous
// scan, and each bit that rose gives one event beat (module, contact 1..16,
// last flag), bit 7 first. Nothing is reported during the first scan after
// reset. A byte that raises no event is taken every cycle while the event
// stage is not busy; a byte that raises events stalls the input while the
// single result register emits one event per cycle unless the output
// stalls. Events pass the pending mask stage, then the result register.
// A new byte is taken while the last event of the previous one waits there.
// ----------------------------------------------------------------------------
module sensor_scan_rising_edge_reporter #(
  parameter int unsigned SCAN_BYTES = ssrer_pkg::ScanBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ssrer_pkg::ByteW-1:0]    sensor_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssrer_pkg::ModuleW-1:0]  module_letter_o,
  output logic [ssrer_pkg::ContactW-1:0] contact_number_o,
  output logic                           last_event_o
);
  import ssrer_pkg::*;

  logic  accept;
  logic  busy;
  edge_t edge_info;

  // Input beat is taken whenever the event stage can absorb it
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  ssrer_scan_mem #(
    .SCAN_BYTES(SCAN_BYTES)
  ) u_scan_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sensor_byte_i(sensor_byte_i),
    .edge_o       (edge_info)
  );

  ssrer_event_ser u_event_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .edge_i          (edge_info),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .module_letter_o (module_letter_o),
    .contact_number_o(contact_number_o),
    .last_event_o    (last_event_o)
  );

endmodule

FILE: bench/sensor_scan_rising_edge_reporter_tb.sv
// ----------------------------------------------------------------------------
// sensor_scan_rising_edge_reporter_tb
// Self-checking bench for the sensor scan rising-edge reporter.
// ----------------------------------------------------------------------------
// A short table of dump bytes covers the baseline scan, full and single-bit
// rises, falling bytes and the last module. Random bytes follow, weighted
// towards all-zero and all-one values so that rises stay frequent. Every
// accepted byte updates a scan-memory model; its events are queued from its
// table row when typed, else by the model. Each event beat out of the block
// is checked against the oldest queued one. The sender runs in bursts; the
// receiver stalls on its own pattern, one long hold-off and one full drain.
// ----------------------------------------------------------------------------
module sensor_scan_rising_edge_reporter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssrer_pkg::*;

  localparam int ScanLen     = ScanBytesDef;
  localparam int DirRows     = 23;
  localparam int RandItems   = 370;
  localparam int HoldCycles  = 300;
  localparam int HoldAtItem  = 100;
  localparam int DrainAtItem = 250;
  localparam int IdleLimit   = 4000;
  localparam int TailCycles  = 20;

  typedef struct packed {
    logic [ModuleW-1:0]  mod_idx;
    logic [ContactW-1:0] contact;
    logic                last;
  } trip_t;

  // One directed byte; when typed, the events are a run of n contacts
  typedef struct {
    logic [ByteW-1:0] data;
    bit               typed;
    int               n;
    int               mod_idx;
    int               first;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ByteW-1:0]    sensor_byte_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ModuleW-1:0]  module_letter_o;
  logic [ContactW-1:0] contact_number_o;
  logic                last_event_o;

  // Side-band of the byte on offer, held with it while stalled
  bit row_typed;
  int row_n;
  int row_mod;
  int row_first;

  // Scan memory of the model
  logic [ByteW-1:0] seen_bytes [ScanLen] = '{default: '0};
  int               scan_pos = 0;
  bit               baseline_seen = 1'b0;

  trip_t    trip_q [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       hold_req;
  bit       hold_taken = 1'b0;
  int       hold_left = 0;
  logic [5:0] pat_cnt = '0;
  int       pat_mode = 0;
  dir_row_t dir_tbl [DirRows];

  sensor_scan_rising_edge_reporter #(
    .SCAN_BYTES(ScanLen)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sensor_byte_i   (sensor_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .module_letter_o (module_letter_o),
    .contact_number_o(contact_number_o),
    .last_event_o    (last_event_o)
  );

  always #4 clk_i = ~clk_i;

  // Model of one dump byte: queue its rising contacts if asked, then update memory
  function automatic void predict_trips(input logic [ByteW-1:0] b, input bit queue_it);
    logic [ByteW-1:0] rise;
    trip_t            evs [$];
    trip_t            ev;
    rise = b & ~seen_bytes[scan_pos];
    if (baseline_seen) begin
      for (int r = 0; r < 8; r++) begin
        if (rise[7-r]) begin
          ev.mod_idx = ModuleW'(scan_pos / 2);
          ev.contact = ContactW'(r + 1 + 8 * (scan_pos % 2));
          ev.last    = 1'b0;
          evs.push_back(ev);
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    if (queue_it) begin
      foreach (evs[k]) trip_q.push_back(evs[k]);
    end
    seen_bytes[scan_pos] = b;
    if (scan_pos == ScanLen - 1) begin
      scan_pos      = 0;
      baseline_seen = 1'b1;
    end else begin
      scan_pos++;
    end
  endfunction

  // Random dump byte, biased towards values that give rises and falls
  function automatic logic [ByteW-1:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: pick_byte = 8'h00;
      3, 4:    pick_byte = 8'hFF;
      5:       pick_byte = 8'h01 << $urandom_range(0, 7);
      6:       pick_byte = ~(8'h01 << $urandom_range(0, 7));
      default: pick_byte = ByteW'($urandom);
    endcase
  endfunction

  task automatic report_bad(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Offer one byte and wait for its beat to be taken
  task automatic offer_byte(input logic [ByteW-1:0] b, input bit typed, input int n,
                            input int mod_idx, input int first);
    in_valid_i    <= 1'b1;
    sensor_byte_i <= b;
    row_typed     <= typed;
    row_n         <= n;
    row_mod       <= mod_idx;
    row_first     <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Input beats feed the model; event beats are checked against it
  always @(posedge clk_i) begin
    trip_t want;
    trip_t got;
    trip_t ev;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (row_typed) begin
        for (int k = 0; k < row_n; k++) begin
          ev.mod_idx = ModuleW'(row_mod);
          ev.contact = ContactW'(row_first + k);
          ev.last    = (k == row_n - 1);
          trip_q.push_back(ev);
        end
        predict_trips(sensor_byte_i, 1'b0);
      end else begin
        predict_trips(sensor_byte_i, 1'b1);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{mod_idx: module_letter_o, contact: contact_number_o, last: last_event_o};
      if (trip_q.size() == 0) begin
        report_bad($sformatf("unexpected event: module %0d contact %0d last %0b",
                             got.mod_idx, got.contact, got.last));
      end else begin
        want = trip_q.pop_front();
        if (got.mod_idx !== want.mod_idx || got.contact !== want.contact ||
            got.last !== want.last) begin
          report_bad($sformatf({"event mismatch: expected module %0d contact %0d ",
                                "last %0b, got module %0d contact %0d last %0b"},
                               want.mod_idx, want.contact, want.last,
                               got.mod_idx, got.contact, got.last));
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    pat_cnt <= pat_cnt + 1'b1;
    if (pat_cnt == '0) pat_mode <= $urandom_range(0, 3);
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (pat_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 99) < 20);
        2:       out_stall_i <= ($urandom_range(0, 99) < 70);
        default: out_stall_i <= (pat_cnt[2:0] < 3'd3);
      endcase
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    sensor_byte_i <= '0;
    row_typed     <= 1'b0;
    row_n         <= 0;
    row_mod       <= 0;
    row_first     <= 0;
    hold_req      <= 1'b0;

    dir_tbl = '{
      // baseline scan: nothing reported
      '{8'hFF, 1, 0, 0, 0}, '{8'h00, 1, 0, 0, 0}, '{8'h55, 1, 0, 0, 0},
      '{8'hAA, 1, 0, 0, 0}, '{8'h00, 1, 0, 0, 0}, '{8'h00, 1, 0, 0, 0},
      '{8'h0F, 1, 0, 0, 0}, '{8'hF0, 1, 0, 0, 0}, '{8'h00, 1, 0, 0, 0},
      '{8'h00, 1, 0, 0, 0},
      // second scan: unchanged, full rise on odd byte, alternating bits
      '{8'hFF, 1, 0, 0, 0}, '{8'hFF, 1, 8, 0, 9}, '{8'hAA, 0, 0, 0, 0},
      '{8'h55, 0, 0, 0, 0},
      // single top and bottom bits, a falling byte, partial rise
      '{8'h80, 1, 1, 2, 1}, '{8'h01, 1, 1, 2, 16}, '{8'h00, 1, 0, 0, 0},
      '{8'hFF, 0, 0, 0, 0},
      // last module, both halves
      '{8'hFF, 1, 8, 4, 1}, '{8'hFF, 1, 8, 4, 9},
      // third scan: falls, then a rise over an old pattern
      '{8'h00, 1, 0, 0, 0}, '{8'h00, 1, 0, 0, 0}, '{8'hFF, 0, 0, 0, 0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_tbl[i]) begin
      offer_byte(dir_tbl[i].data, dir_tbl[i].typed, dir_tbl[i].n,
                 dir_tbl[i].mod_idx, dir_tbl[i].first);
      if ($urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end

    // Random bytes in bursts
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < RandItems; i++) begin
      offer_byte(pick_byte(), 1'b0, 0, 0, 0);
      if (i == HoldAtItem) hold_req <= 1'b1;
      if (i == DrainAtItem) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (trip_q.size() != 0) @(posedge clk_i);
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
          gap = $urandom_range(1, 6);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (trip_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ssrer_pkg.sv
rtl/core/ssrer_scan_mem.sv
rtl/core/ssrer_event_ser.sv
rtl/core/sensor_scan_rising_edge_reporter.sv
bench/sensor_scan_rising_edge_reporter_tb.sv
